// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Clocked check, off while reset is asserted.
`define FCW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds during reset.
`define FCW_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FCW_ASSERT(lbl, clk, rst_n, prop, msg)
`define FCW_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== hw/rtl/fcw_pkg.sv =====
// Shared constants, types and helpers of the FAT cluster chain walker.
`default_nettype none
package fcw_pkg;

  localparam int TABLE_BYTES = 65536;
  localparam int CLU_W       = 16;
  localparam int OFF_W       = CLU_W + 1;
  localparam int CMP_W       = 18;
  localparam int BANK_DEPTH  = (TABLE_BYTES + 1) / 2;
  localparam int BANK_W      = $clog2(BANK_DEPTH);

  localparam logic [CMP_W-1:0] TABLE_BYTES_C = CMP_W'(TABLE_BYTES);
  localparam logic [CLU_W-1:0] END16         = 16'hFFF8;
  localparam logic [11:0]      END12         = 12'hFF8;
  localparam logic [11:0]      MASK12        = 12'hFFF;

  typedef enum logic [1:0] {
    ACT_LOAD    = 2'd0,
    ACT_START   = 2'd1,
    ACT_ADVANCE = 2'd2,
    ACT_NONE    = 2'd3
  } fcw_action_t;

  // Advance transaction in flight between read issue and decode.
  typedef struct packed {
    logic fat16;      // mode sampled at accept
    logic odd_n;      // cluster number odd
    logic swap;       // entry offset odd: low byte sits in the odd bank
    logic oor;        // entry lies beyond the store
  } fcw_rd_t;

  typedef struct packed {
    logic [CLU_W-1:0] cluster;
    logic             chain_end;
    logic             oor;
  } fcw_res_t;

  function automatic logic is_end_marker(input logic [CLU_W-1:0] c, input logic fat16);
    logic r;
    if (fat16) r = (c >= END16);
    else       r = ((c[11:0] & MASK12) >= END12);
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/fcw_byte_bank.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module fcw_byte_bank #(
  parameter int DEPTH = 32768,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

// ===== hw/rtl/fcw_entry_decode.sv =====
// Turns the two bytes read from the banks into the next cluster and its flags.
`default_nettype none
module fcw_entry_decode (
  input  wire fcw_pkg::fcw_rd_t rd_info,
  input  wire logic [7:0]       even_byte,
  input  wire logic [7:0]       odd_byte,
  output fcw_pkg::fcw_res_t     res
);
  import fcw_pkg::*;

  logic [CLU_W-1:0] word;
  logic [CLU_W-1:0] next;

  always_comb begin
    word = rd_info.swap ? {even_byte, odd_byte} : {odd_byte, even_byte};
    if (rd_info.fat16)      next = word;
    else if (rd_info.odd_n) next = {4'd0, word[CLU_W-1:4]};
    else                    next = {4'd0, word[11:0] & MASK12};

    if (rd_info.oor) begin
      res.cluster   = '0;
      res.chain_end = 1'b1;
      res.oor       = 1'b1;
    end else begin
      res.cluster   = next;
      res.chain_end = is_end_marker(next, rd_info.fat16);
      res.oor       = 1'b0;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/fat_cluster_chain_walker_unit.sv =====
// Top level of the FAT cluster chain walker: command port, byte banks, chain state.
// Timing: a load writes its bank at accept and gives no result; a start result
//   appears the cycle after accept; an advance result is registered after the bank read.
// Throughput: one load, start or dropped command per cycle when not busy; an advance on a
//   live chain holds busy until its bytes are decoded, due to the synchronous bank read.
// Reset (rst_n low, synchronous): clears mode, chain state and the result strobe;
//   table contents stay undefined until written. The receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"
module fat_cluster_chain_walker_unit (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // command channel
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                in_action,
  input  wire logic [15:0]               in_byte_address,
  input  wire logic [7:0]                in_byte_value,
  input  wire logic [fcw_pkg::CLU_W-1:0] in_start_cluster,
  // configuration
  input  wire logic                      cfg_wr_en,
  input  wire logic                      cfg_wr_data,
  // results
  output logic                           out_valid,
  output logic [fcw_pkg::CLU_W-1:0]      out_cluster,
  output logic                           out_chain_end,
  output logic                           out_out_of_range
);
  import fcw_pkg::*;

  // Architectural state
  logic             fat16_r;
  logic [CLU_W-1:0] cur_r,    cur_nxt;
  logic             active_r, active_nxt;

  // Advance in flight: read issued, bytes arrive next cycle
  logic    pend_r, pend_nxt;
  fcw_rd_t rd_r,   rd_nxt;

  // Result registers
  logic             out_valid_r, out_valid_nxt;
  logic [CLU_W-1:0] out_cluster_r, out_cluster_nxt;
  logic             out_end_r, out_end_nxt;
  logic             out_oor_r, out_oor_nxt;

  logic        accept;
  fcw_action_t act;
  logic        start_end;

  // Entry offset: 2n in FAT16, n + n/2 (= floor(1.5n)) in FAT12
  logic [OFF_W-1:0] off;
  logic [CMP_W-1:0] off_ext;
  logic             off_oor;
  logic [OFF_W-1:0] even_idx_w;
  logic [BANK_W-1:0] even_rd_idx, odd_rd_idx;

  // Load path
  logic [CMP_W-1:0]  ld_addr_ext;
  logic              ld_ok;
  logic [BANK_W-1:0] ld_idx;
  logic              even_we, odd_we;
  logic              rd_en;

  logic [7:0] even_byte, odd_byte;
  fcw_res_t   res;

  assign busy   = pend_r;
  assign accept = start && !busy;
  assign act    = fcw_action_t'(in_action);

  assign start_end = is_end_marker(in_start_cluster, fat16_r);

  always_comb begin
    if (fat16_r) off = {cur_r, 1'b0};
    else         off = {1'b0, cur_r} + {2'b00, cur_r[CLU_W-1:1]};
  end

  assign off_ext  = {{(CMP_W-OFF_W){1'b0}}, off};
  assign off_oor  = (off_ext + CMP_W'(1)) >= TABLE_BYTES_C;
  // Word at an odd offset starts in the odd bank and ends in the next even row.
  assign even_idx_w  = {1'b0, off[OFF_W-1:1]} + OFF_W'(off[0]);
  assign even_rd_idx = even_idx_w[BANK_W-1:0];
  assign odd_rd_idx  = off_ext[BANK_W:1];

  assign ld_addr_ext = {{(CMP_W-16){1'b0}}, in_byte_address};
  assign ld_ok       = accept && (act == ACT_LOAD) && (ld_addr_ext < TABLE_BYTES_C);
  assign ld_idx      = ld_addr_ext[BANK_W:1];
  assign even_we     = ld_ok && !in_byte_address[0];
  assign odd_we      = ld_ok && in_byte_address[0];

  assign rd_en = accept && (act == ACT_ADVANCE) && active_r && !off_oor;

  fcw_byte_bank #(.DEPTH(BANK_DEPTH), .AW(BANK_W), .DW(8)) u_even_bank (
    .clk     (clk),
    .wr_en   (even_we),
    .wr_addr (ld_idx),
    .wr_data (in_byte_value),
    .rd_en   (rd_en),
    .rd_addr (even_rd_idx),
    .rd_data (even_byte)
  );

  fcw_byte_bank #(.DEPTH(BANK_DEPTH), .AW(BANK_W), .DW(8)) u_odd_bank (
    .clk     (clk),
    .wr_en   (odd_we),
    .wr_addr (ld_idx),
    .wr_data (in_byte_value),
    .rd_en   (rd_en),
    .rd_addr (odd_rd_idx),
    .rd_data (odd_byte)
  );

  fcw_entry_decode u_decode (
    .rd_info   (rd_r),
    .even_byte (even_byte),
    .odd_byte  (odd_byte),
    .res       (res)
  );

  always_comb begin
    cur_nxt         = cur_r;
    active_nxt      = active_r;
    pend_nxt        = 1'b0;
    rd_nxt          = rd_r;
    out_valid_nxt   = 1'b0;
    out_cluster_nxt = out_cluster_r;
    out_end_nxt     = out_end_r;
    out_oor_nxt     = out_oor_r;

    if (pend_r) begin
      // advance in flight: bytes are in, close the transaction
      out_valid_nxt   = 1'b1;
      out_cluster_nxt = res.cluster;
      out_end_nxt     = res.chain_end;
      out_oor_nxt     = res.oor;
      active_nxt      = !res.chain_end;
      if (!res.oor) cur_nxt = res.cluster;
    end else if (accept) begin
      unique case (act)
        ACT_START: begin
          cur_nxt         = in_start_cluster;
          active_nxt      = !start_end;
          out_valid_nxt   = 1'b1;
          out_cluster_nxt = in_start_cluster;
          out_end_nxt     = start_end;
          out_oor_nxt     = 1'b0;
        end
        ACT_ADVANCE: begin
          if (active_r) begin
            pend_nxt     = 1'b1;
            rd_nxt.fat16 = fat16_r;
            rd_nxt.odd_n = cur_r[0];
            rd_nxt.swap  = off[0];
            rd_nxt.oor   = off_oor;
          end
        end
        ACT_LOAD, ACT_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fat16_r     <= 1'b0;
      cur_r       <= '0;
      active_r    <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) fat16_r <= cfg_wr_data;
      cur_r       <= cur_nxt;
      active_r    <= active_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    rd_r          <= rd_nxt;
    out_cluster_r <= out_cluster_nxt;
    out_end_r     <= out_end_nxt;
    out_oor_r     <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_cluster      = out_cluster_r;
  assign out_chain_end    = out_end_r;
  assign out_out_of_range = out_oor_r;

  // every issued advance closes with a result on the next cycle
  `FCW_ASSERT(a_adv_result, clk, rst_n, pend_r |=> out_valid_r, "advance gave no result")
  // an advance in flight is always closed, never left pending
  `FCW_ASSERT(a_adv_one_cycle, clk, rst_n, pend_r |=> !pend_r, "advance stuck in flight")
  // out-of-range results always end the chain with cluster zero
  `FCW_ASSERT(a_oor_ends, clk, rst_n,
    (out_valid_r && out_oor_r) |-> (out_end_r && out_cluster_r == '0 && !active_r),
    "out-of-range result malformed")
  // a start echoes its cluster on the next cycle
  `FCW_ASSERT(a_start_echo, clk, rst_n,
    (accept && act == ACT_START) |=>
      (out_valid_r && out_cluster_r == $past(in_start_cluster) && !out_oor_r),
    "start not echoed")
  // chain active state follows the end flag of the last result
  `FCW_ASSERT(a_active_match, clk, rst_n, out_valid_r |-> (active_r == !out_end_r),
    "chain state disagrees with result")

endmodule
`default_nettype wire

// ===== test/tb_fat_cluster_chain_walker_unit.sv =====
// Self-checking testbench for the FAT cluster chain walker top level.
`timescale 1ns / 100ps
module tb_fat_cluster_chain_walker_unit;
  import fcw_pkg::*;

  // ---------------------------------------------------------------------------
  // Types used by the stimulus and the chain predictor
  // ---------------------------------------------------------------------------
  typedef struct packed {
    fcw_action_t      act;
    logic [15:0]      addr;
    logic [7:0]       val;
    logic [CLU_W-1:0] clu;
  } cmd_t;

  // One row of the directed table: a mode write or a command transaction,
  // optionally with a hand-typed expected result.
  typedef struct {
    bit       is_cfg;
    bit       cfg_val;
    cmd_t     cmd;
    bit       typed;
    fcw_res_t want;
  } row_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 950;
  localparam int PHASE_ITEMS    = 100;
  localparam int DRAIN_CYCLES   = 4;

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [1:0]       in_action;
  logic [15:0]      in_byte_address;
  logic [7:0]       in_byte_value;
  logic [CLU_W-1:0] in_start_cluster;
  logic             cfg_wr_en;
  logic             cfg_wr_data;
  logic             out_valid;
  logic [CLU_W-1:0] out_cluster;
  logic             out_chain_end;
  logic             out_out_of_range;

  fat_cluster_chain_walker_unit DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_action        (in_action),
    .in_byte_address  (in_byte_address),
    .in_byte_value    (in_byte_value),
    .in_start_cluster (in_start_cluster),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .out_valid        (out_valid),
    .out_cluster      (out_cluster),
    .out_chain_end    (out_chain_end),
    .out_out_of_range (out_out_of_range)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow of the block: table bytes, which bytes hold data, chain position
  // ---------------------------------------------------------------------------
  bit [7:0]         fat_bytes [0:TABLE_BYTES-1];
  bit               byte_seen [0:TABLE_BYTES-1];
  logic [CLU_W-1:0] walk_cluster;
  bit               walk_active;
  bit               mode16;

  fcw_res_t walk_results_due [$];   // results owed by the DUT, oldest first
  fcw_res_t head_res;

  int errors;
  int n_load, n_start, n_adv, n_ignored, n_checked, n_oor, n_end, n_mode_wr;
  int quiet_cycles;
  bit idle_en;

  // End-of-chain test under the current entry width.
  function automatic bit is_eoc(input logic [CLU_W-1:0] c);
    if (mode16) return c >= END16;
    return c[11:0] >= END12;
  endfunction

  // Byte offset of the table entry of cluster n: 2n, or n + n/2 for packed
  // 12-bit entries (exact integer form of 1.5n).
  function automatic int entry_off(input logic [CLU_W-1:0] n);
    if (mode16) return int'(n) * 2;
    return int'(n) + int'(n >> 1);
  endfunction

  // Applies one accepted command to the shadow state; returns 1 and the
  // result when the command produces one.
  function automatic bit fat_next(input cmd_t c, output fcw_res_t r);
    int               off;
    logic [15:0]      w;
    logic [CLU_W-1:0] nxt;
    r = '0;
    case (c.act)
      ACT_LOAD: begin
        fat_bytes[c.addr] = c.val;
        byte_seen[c.addr] = 1'b1;
        return 1'b0;
      end
      ACT_START: begin
        walk_cluster = c.clu;
        walk_active  = !is_eoc(c.clu);
        r.cluster    = c.clu;
        r.chain_end  = !walk_active;
        return 1'b1;
      end
      ACT_ADVANCE: begin
        if (!walk_active) return 1'b0;
        off = entry_off(walk_cluster);
        // both entry bytes must sit inside the store
        if (off + 1 >= TABLE_BYTES) begin
          walk_active = 1'b0;
          r.chain_end = 1'b1;
          r.oor       = 1'b1;
          return 1'b1;
        end
        w = {fat_bytes[off+1], fat_bytes[off]};
        if (mode16)               nxt = w;
        else if (walk_cluster[0]) nxt = {4'h0, w[15:4]};
        else                      nxt = {4'h0, w[11:0]};
        walk_cluster = nxt;
        walk_active  = !is_eoc(nxt);
        r.cluster    = nxt;
        r.chain_end  = !walk_active;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic cmd_t mk(input fcw_action_t a, input logic [15:0] addr,
                              input logic [7:0] val, input logic [CLU_W-1:0] clu);
    cmd_t c;
    c.act  = a;
    c.addr = addr;
    c.val  = val;
    c.clu  = clu;
    return c;
  endfunction

  function automatic row_t row_cmd(input fcw_action_t a, input logic [15:0] addr,
                                   input logic [7:0] val, input logic [CLU_W-1:0] clu);
    row_t r;
    r.is_cfg  = 1'b0;
    r.cfg_val = 1'b0;
    r.cmd     = mk(a, addr, val, clu);
    r.typed   = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic row_t row_chk(input fcw_action_t a, input logic [CLU_W-1:0] clu,
                                   input logic [CLU_W-1:0] res_clu, input bit e, input bit o);
    row_t r;
    r = row_cmd(a, 16'h0000, 8'h00, clu);
    r.typed          = 1'b1;
    r.want.cluster   = res_clu;
    r.want.chain_end = e;
    r.want.oor       = o;
    return r;
  endfunction

  function automatic row_t row_cfg(input bit v);
    row_t r;
    r = row_cmd(ACT_NONE, 16'h0000, 8'h00, '0);
    r.is_cfg  = 1'b1;
    r.cfg_val = v;
    return r;
  endfunction

  // Cluster pick for starts and for freshly written entries: end markers,
  // wide values (out-of-range entries in 16-bit mode), and many small ones so
  // chains wander back over entries that are already loaded.
  function automatic logic [CLU_W-1:0] pick_cluster();
    int               r;
    logic [CLU_W-1:0] v;
    r = $urandom_range(99);
    if (r < 14) begin
      if (mode16) v = END16 + 16'($urandom_range(7));
      else        v = {4'($urandom_range(15)), END12 + 12'($urandom_range(7))};
    end else if (r < 24) begin
      v = 16'($urandom);
    end else if (r < 30 && mode16) begin
      v = 16'h8000 + 16'($urandom_range(16'h7FF7));
    end else begin
      v = 16'($urandom_range(600));
    end
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Command driver: inputs change on the falling edge, the handshake is
  // sampled on the rising edge. Called and returns on a falling edge.
  // ---------------------------------------------------------------------------
  task automatic drive(input cmd_t c, input bit typed, input fcw_res_t want);
    fcw_res_t r;
    bit       has;
    while (idle_en && $urandom_range(99) < 34) begin
      start            = 1'b0;
      in_action        = 2'($urandom);
      in_byte_address  = 16'($urandom);
      in_byte_value    = 8'($urandom);
      in_start_cluster = 16'($urandom);
      @(negedge clk);
    end
    start            = 1'b1;
    in_action        = c.act;
    in_byte_address  = c.addr;
    in_byte_value    = c.val;
    in_start_cluster = c.clu;
    do @(posedge clk); while (busy);
    // transaction accepted at this edge
    has = fat_next(c, r);
    if (has) begin
      walk_results_due.push_back(typed ? want : r);
      if (c.act == ACT_START) n_start++;
      else                    n_adv++;
    end else if (c.act == ACT_LOAD) begin
      n_load++;
    end else begin
      n_ignored++;
    end
    @(negedge clk);
  endtask

  // Holds the sender off until every owed result is back and the pipe is quiet.
  task automatic wait_drained();
    start = 1'b0;
    while (walk_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mode register write; only issued from an idle block.
  task automatic write_mode(input bit v);
    wait_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    mode16    = v;
    n_mode_wr++;
  endtask

  // Loads the table entry of cluster n so that it points at nxt. In 12-bit
  // mode the neighbor's nibble in the shared byte is kept.
  task automatic write_entry(input logic [CLU_W-1:0] n, input logic [CLU_W-1:0] nxt);
    int         off;
    logic [7:0] b0, b1;
    off = entry_off(n);
    if (mode16) begin
      b0 = nxt[7:0];
      b1 = nxt[15:8];
    end else if (n[0]) begin
      b0 = {nxt[3:0], fat_bytes[off][3:0]};
      b1 = nxt[11:4];
    end else begin
      b0 = nxt[7:0];
      b1 = {fat_bytes[off+1][7:4], nxt[11:8]};
    end
    if ($urandom_range(1)) begin
      drive(mk(ACT_LOAD, 16'(off), b0, 16'($urandom)), 1'b0, '0);
      drive(mk(ACT_LOAD, 16'(off + 1), b1, 16'($urandom)), 1'b0, '0);
    end else begin
      drive(mk(ACT_LOAD, 16'(off + 1), b1, 16'($urandom)), 1'b0, '0);
      drive(mk(ACT_LOAD, 16'(off), b0, 16'($urandom)), 1'b0, '0);
    end
  endtask

  // Advance on the current chain. An entry that was never loaded is written
  // first; a loaded one is rewritten about half the time.
  task automatic advance_chain();
    int off;
    if (walk_active) begin
      off = entry_off(walk_cluster);
      if (off + 1 < TABLE_BYTES &&
          (!byte_seen[off] || !byte_seen[off+1] || $urandom_range(99) < 55))
        write_entry(walk_cluster, pick_cluster());
    end
    drive(mk(ACT_ADVANCE, 16'($urandom), 8'($urandom), 16'($urandom)), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: every strobe must match the oldest owed result
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      n_checked++;
      if (walk_results_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: expected nothing, actual cluster=%h end=%b oor=%b",
                 $time, out_cluster, out_chain_end, out_out_of_range);
      end else begin
        head_res = walk_results_due.pop_front();
        if (head_res.oor) n_oor++;
        if (head_res.chain_end) n_end++;
        if (out_cluster !== head_res.cluster) begin
          errors++;
          $display("%0t: cluster mismatch: expected %h, actual %h",
                   $time, head_res.cluster, out_cluster);
        end
        if (out_chain_end !== head_res.chain_end) begin
          errors++;
          $display("%0t: chain_end mismatch: expected %b, actual %b",
                   $time, head_res.chain_end, out_chain_end);
        end
        if (out_out_of_range !== head_res.oor) begin
          errors++;
          $display("%0t: out_of_range mismatch: expected %b, actual %b",
                   $time, head_res.oor, out_out_of_range);
        end
      end
    end
  end

  // Watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if ((rst_n && start && !busy) || (rst_n && out_valid)) quiet_cycles <= 0;
    else                                                   quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results still owed",
               $time, walk_results_due.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  row_t dir_rows [$];

  initial begin
    int  base, done, next_phase, phase;
    bit  m;
    // all inputs known from time zero
    rst_n            = 1'b0;
    start            = 1'b0;
    in_action        = ACT_LOAD;
    in_byte_address  = '0;
    in_byte_value    = '0;
    in_start_cluster = '0;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = 1'b0;
    errors           = 0;
    quiet_cycles     = 0;
    walk_cluster     = '0;
    walk_active      = 1'b0;
    mode16           = 1'b0;
    idle_en          = 1'b1;

    // Directed table. Reset leaves 12-bit mode and no chain.
    dir_rows.push_back(row_cmd(ACT_ADVANCE, 16'h1234, 8'h56, 16'h0000)); // no chain: dropped
    dir_rows.push_back(row_cmd(ACT_NONE, 16'hFFFF, 8'hFF, 16'hFFFF));    // unused code: dropped
    // start values that are end markers and one that is not; 12-bit tests low 12 bits only
    dir_rows.push_back(row_chk(ACT_START, 16'h0FF8, 16'h0FF8, 1'b1, 1'b0));
    dir_rows.push_back(row_chk(ACT_START, 16'h1FF8, 16'h1FF8, 1'b1, 1'b0));
    dir_rows.push_back(row_chk(ACT_START, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
    dir_rows.push_back(row_chk(ACT_START, 16'h0000, 16'h0000, 1'b0, 1'b0));
    // 12-bit chain 2 -> 3 -> FFF: even entry masked, odd entry shifted
    dir_rows.push_back(row_cmd(ACT_LOAD, 16'h0003, 8'h03, 16'h0000));
    dir_rows.push_back(row_cmd(ACT_LOAD, 16'h0004, 8'hF0, 16'h0000));
    dir_rows.push_back(row_cmd(ACT_LOAD, 16'h0005, 8'hFF, 16'h0000));
    dir_rows.push_back(row_chk(ACT_START, 16'h0002, 16'h0002, 1'b0, 1'b0));
    dir_rows.push_back(row_cmd(ACT_ADVANCE, 16'h0000, 8'h00, 16'h0000));
    dir_rows.push_back(row_cmd(ACT_ADVANCE, 16'h0000, 8'h00, 16'h0000));
    dir_rows.push_back(row_cmd(ACT_ADVANCE, 16'h0000, 8'h00, 16'h0000)); // chain over
    // first 12-bit cluster whose entry runs past the store
    dir_rows.push_back(row_chk(ACT_START, 16'hAAAA, 16'hAAAA, 1'b0, 1'b0));
    dir_rows.push_back(row_chk(ACT_ADVANCE, 16'h0000, 16'h0000, 1'b1, 1'b1));
    // address extremes
    dir_rows.push_back(row_cmd(ACT_LOAD, 16'h0000, 8'h00, 16'h0000));
    dir_rows.push_back(row_cmd(ACT_LOAD, 16'hFFFE, 8'hF8, 16'h0000));
    dir_rows.push_back(row_cmd(ACT_LOAD, 16'hFFFF, 8'hFF, 16'h0000));
    dir_rows.push_back(row_cfg(1'b1));
    // 16-bit mode: end marker bound, out-of-range entries, last entry in store
    dir_rows.push_back(row_chk(ACT_START, 16'hFFF8, 16'hFFF8, 1'b1, 1'b0));
    dir_rows.push_back(row_chk(ACT_START, 16'hFFF7, 16'hFFF7, 1'b0, 1'b0));
    dir_rows.push_back(row_chk(ACT_ADVANCE, 16'h0000, 16'h0000, 1'b1, 1'b1));
    dir_rows.push_back(row_chk(ACT_START, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0));
    dir_rows.push_back(row_cmd(ACT_ADVANCE, 16'h0000, 8'h00, 16'h0000));
    dir_rows.push_back(row_chk(ACT_START, 16'h0002, 16'h0002, 1'b0, 1'b0));
    dir_rows.push_back(row_cmd(ACT_ADVANCE, 16'h0000, 8'h00, 16'h0000));
    dir_rows.push_back(row_chk(ACT_ADVANCE, 16'h0000, 16'h0000, 1'b1, 1'b1));
    dir_rows.push_back(row_cfg(1'b0));

    // synchronous reset, released on a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) write_mode(dir_rows[i].cfg_val);
      else drive(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);
    end

    // Random part in phases of about PHASE_ITEMS transactions; the mode is
    // rewritten between phases from an idle block. Most traffic is chains:
    // start, entry loads, advances. A few percent is noise.
    base       = n_load + n_start + n_adv;
    next_phase = PHASE_ITEMS;
    phase      = 0;
    m          = 1'b1;
    write_mode(m);
    done = 0;
    while (done < RANDOM_ITEMS) begin
      if (done >= next_phase) begin
        phase++;
        next_phase += PHASE_ITEMS;
        m = (phase == 1) ? 1'b0 : 1'($urandom_range(1));
        write_mode(m);
      end
      // one long stretch with the sender never idling
      idle_en = !(done >= 350 && done < 500);
      case ($urandom_range(99)) inside
        [0:1]:   drive(mk(ACT_LOAD, 16'($urandom), 8'($urandom), 16'($urandom)), 1'b0, '0);
        [2:3]:   drive(mk(ACT_NONE, 16'($urandom), 8'($urandom), 16'($urandom)), 1'b0, '0);
        [4:5]:   drive(mk(ACT_START, 16'($urandom), 8'($urandom), 16'($urandom)), 1'b0, '0);
        [6:7]:   advance_chain();
        [8:19]:  drive(mk(ACT_START, 16'($urandom), 8'($urandom), pick_cluster()), 1'b0, '0);
        default: begin
          if (walk_active) advance_chain();
          else drive(mk(ACT_START, 16'($urandom), 8'($urandom), pick_cluster()), 1'b0, '0);
        end
      endcase
      done = n_load + n_start + n_adv - base;
    end

    // drain and let the pipe settle; a late stray strobe is still caught
    start = 1'b0;
    while (walk_results_due.size() != 0) @(negedge clk);
    repeat (2 * DRAIN_CYCLES) @(negedge clk);

    $display("Covered %0d loads, %0d starts, %0d advances, %0d dropped commands, %0d mode writes",
             n_load, n_start, n_adv, n_ignored, n_mode_wr);
    $display("Checked %0d results: %0d chain ends, %0d out-of-range entries",
             n_checked, n_end, n_oor);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== fat_cluster_chain_walker_unit.f =====
+incdir+hw/rtl
hw/rtl/fcw_pkg.sv
hw/rtl/fcw_byte_bank.sv
hw/rtl/fcw_entry_decode.sv
hw/rtl/fat_cluster_chain_walker_unit.sv
test/tb_fat_cluster_chain_walker_unit.sv
